// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define BPSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every clk edge outside reset.
`define BPSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bpsc_pkg.sv =====
package bpsc_pkg;

  localparam int MV_W   = 13;
  localparam int CUR_W  = 24;
  localparam int THR_W  = 23;
  localparam int GSOC_W = 8;
  localparam int SOC_W  = 7;
  localparam int QW     = 7;   // quotient bits: estimate stays below 128
  localparam int NUM_W  = 20;  // 8191 * 100 fits in 20 bits
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W  = 23;
  // input edge to the edge that samples the strobe: three front stages,
  // the divider stages and the output register
  localparam int LATENCY = 4 + QW;

  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;

  localparam logic [MV_W-1:0]  LIION_MIN_MV = 13'd3000;
  localparam logic [MV_W-1:0]  DEAD_RAIL_MV = 13'd2500;
  localparam logic [SOC_W:0]   CLAMP_MARGIN = 8'd25;
  localparam logic [SOC_W-1:0] CLAMP_LIMIT  = 7'd80;
  localparam logic [SOC_W-1:0] SOC_FULL     = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY   = 3'd0,
    CFG_FULL    = 3'd1,
    CFG_PRESENT = 3'd2,
    CFG_IDLE    = 3'd3,
    CFG_AGREE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_GAUGE = 2'd1,
    SRC_LIN   = 2'd2,
    SRC_NONE  = 2'd3
  } soc_src_t;

  // what travels alongside the divider
  typedef struct packed {
    logic [1:0]       pack_state;
    soc_src_t         src;
    logic [SOC_W-1:0] gsoc;
    logic             lo;
    logic             hi;
  } side_t;

endpackage

// ===== rtl/battery_presence_and_soc_classifier.sv =====
// Channel   Handshake              Ports
// input     start high, busy low   in_pmic_vbat_mv .. in_gauge_soc
// result    out_strobe, one cycle  out_pack_state, out_charge_pct, out_soc_valid
// config    cfg_we, no wait        cfg_index, cfg_wdata
//
// One sample may enter every cycle while busy is low. Its strobe rises behind
// the three front stages, the 7-stage restoring divider of the linear voltage
// estimate and the one output stage.
// busy is high only during reset; a synchronous reset clears the valid bits
// and loads the register defaults. The result is shown for one cycle and cannot
// be held off.
module battery_presence_and_soc_classifier
  import bpsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [MV_W-1:0]         in_pmic_vbat_mv,
  input  logic [MV_W-1:0]         in_gauge_vcell_mv,
  input  logic signed [CUR_W-1:0] in_cell_current_ua,
  input  logic                    in_usb_online,
  input  logic                    in_reg_done,
  input  logic                    in_bat_good,
  input  logic                    in_pack_absent,
  input  logic signed [GSOC_W-1:0] in_gauge_soc,
  output logic                    out_strobe,
  output logic [1:0]              out_pack_state,
  output logic [SOC_W-1:0]        out_charge_pct,
  output logic                    out_soc_valid,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  `include "assert_macros.svh"

  // configuration registers
  logic [MV_W-1:0]  cfg_empty_r, cfg_full_r, cfg_agree_r;
  logic [THR_W-1:0] cfg_present_r, cfg_idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_empty_r   <= 13'd3300;
      cfg_full_r    <= 13'd4200;
      cfg_present_r <= 23'd30000;
      cfg_idle_r    <= 23'd30000;
      cfg_agree_r   <= 13'd400;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EMPTY:   cfg_empty_r   <= cfg_wdata[MV_W-1:0];
        CFG_FULL:    cfg_full_r    <= cfg_wdata[MV_W-1:0];
        CFG_PRESENT: cfg_present_r <= cfg_wdata;
        CFG_IDLE:    cfg_idle_r    <= cfg_wdata;
        CFG_AGREE:   cfg_agree_r   <= cfg_wdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  logic in_accept;
  assign busy      = ~rst_n;
  assign in_accept = start & ~busy;

  // ---------------- stage 1: magnitudes and voltage flags
  logic             s1_v_r;
  logic [CUR_W-1:0] s1_ia_r;
  logic [MV_W-1:0]  s1_pm_r, s1_fg_r;
  logic             s1_usb_r, s1_done_r, s1_good_r, s1_absent_r;
  logic             s1_gvalid_r;
  logic [SOC_W-1:0] s1_gsoc_r;
  logic             s1_pm_nz_r, s1_fg_nz_r, s1_pm_ge_r, s1_fg_ge_r, s1_pm_dead_r;
  logic             s1_agree_r;

  logic [CUR_W-1:0] ia_nxt;
  logic [MV_W-1:0]  vdiff_nxt;

  assign ia_nxt    = in_cell_current_ua[CUR_W-1] ? CUR_W'(-in_cell_current_ua)
                                                 : CUR_W'(in_cell_current_ua);
  assign vdiff_nxt = (in_pmic_vbat_mv >= in_gauge_vcell_mv)
                   ? in_pmic_vbat_mv - in_gauge_vcell_mv
                   : in_gauge_vcell_mv - in_pmic_vbat_mv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_ia_r      <= ia_nxt;
    s1_pm_r      <= in_pmic_vbat_mv;
    s1_fg_r      <= in_gauge_vcell_mv;
    s1_usb_r     <= in_usb_online;
    s1_done_r    <= in_reg_done;
    s1_good_r    <= in_bat_good;
    s1_absent_r  <= in_pack_absent;
    s1_gvalid_r  <= ~in_gauge_soc[GSOC_W-1] && (in_gauge_soc[SOC_W-1:0] <= SOC_FULL);
    s1_gsoc_r    <= in_gauge_soc[SOC_W-1:0];
    s1_pm_nz_r   <= (in_pmic_vbat_mv != '0);
    s1_fg_nz_r   <= (in_gauge_vcell_mv != '0);
    s1_pm_ge_r   <= (in_pmic_vbat_mv >= LIION_MIN_MV);
    s1_fg_ge_r   <= (in_gauge_vcell_mv >= LIION_MIN_MV);
    s1_pm_dead_r <= (in_pmic_vbat_mv < DEAD_RAIL_MV);
    s1_agree_r   <= (vdiff_nxt < cfg_agree_r);
  end

  // ---------------- stage 2: rule ladder, source pick, estimate operands
  logic             ia_lt_idle, ia_gt_idle, ia_ge_pres;
  logic [1:0]       st_nxt;
  soc_src_t         src_nxt;
  logic [MV_W-1:0]  mv_nxt;

  assign ia_lt_idle = s1_ia_r <  CUR_W'(cfg_idle_r);
  assign ia_gt_idle = s1_ia_r >  CUR_W'(cfg_idle_r);
  assign ia_ge_pres = s1_ia_r >= CUR_W'(cfg_present_r);

  always_comb begin
    st_nxt = ST_UNKNOWN;
    if (s1_usb_r && s1_done_r && ia_lt_idle) begin
      st_nxt = ST_ABSENT;
    end else if (s1_usb_r && ia_ge_pres) begin
      st_nxt = ST_PRESENT;
    end else if (s1_usb_r && !s1_absent_r && s1_fg_ge_r) begin
      st_nxt = ST_PRESENT;
    end else if (s1_usb_r && !s1_good_r && s1_pm_nz_r && s1_pm_dead_r) begin
      st_nxt = ST_ABSENT;
    end else if (!s1_usb_r && s1_pm_nz_r && !s1_pm_ge_r && s1_fg_nz_r && !s1_fg_ge_r) begin
      st_nxt = ST_ABSENT;
    end else if (!s1_usb_r && (s1_pm_ge_r || s1_fg_ge_r)) begin
      st_nxt = ST_PRESENT;
    end else if (!s1_usb_r && ia_gt_idle) begin
      st_nxt = ST_PRESENT;
    end else if (s1_pm_ge_r && s1_fg_ge_r && (s1_agree_r || ia_ge_pres)) begin
      st_nxt = ST_PRESENT;
    end
  end

  always_comb begin
    if (st_nxt == ST_ABSENT) begin
      src_nxt = SRC_ZERO;
    end else if (s1_usb_r && st_nxt == ST_UNKNOWN && ia_lt_idle && s1_absent_r) begin
      src_nxt = SRC_ZERO;
    end else if (s1_gvalid_r) begin
      src_nxt = SRC_GAUGE;
    end else if (s1_pm_nz_r || s1_fg_nz_r) begin
      src_nxt = SRC_LIN;
    end else begin
      src_nxt = SRC_NONE;
    end
  end

  // the gauge clamp always uses the PMIC voltage, even when it is zero
  assign mv_nxt = (s1_gvalid_r || s1_pm_nz_r) ? s1_pm_r : s1_fg_r;

  logic             s2_v_r;
  side_t            s2_side_r;
  logic [MV_W-1:0]  s2_diff_r, s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r.pack_state <= st_nxt;
    s2_side_r.src        <= src_nxt;
    s2_side_r.gsoc       <= s1_gsoc_r;
    s2_side_r.lo         <= (mv_nxt <= cfg_empty_r);
    s2_side_r.hi         <= (mv_nxt >= cfg_full_r);
    s2_diff_r            <= mv_nxt - cfg_empty_r;
    s2_den_r             <= cfg_full_r - cfg_empty_r;
  end

  // ---------------- stage 3: scale the numerator by 100
  logic             s3_v_r;
  side_t            s3_side_r;
  logic [NUM_W-1:0] s3_num_r;
  logic [MV_W-1:0]  s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_side_r <= s2_side_r;
    s3_num_r  <= NUM_W'(s2_diff_r) * NUM_W'(SOC_FULL);
    s3_den_r  <= s2_den_r;
  end

  // ---------------- divider stages
  logic          dv_v;
  logic [QW-1:0] dv_quo;
  side_t         dv_side;

  bpsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---------------- output stage: estimate, clamp, select
  logic [SOC_W-1:0] est;
  logic [SOC_W-1:0] soc_nxt;
  logic             valid_nxt;

  always_comb begin
    if (dv_side.lo) begin
      est = '0;
    end else if (dv_side.hi) begin
      est = SOC_FULL;
    end else begin
      est = SOC_W'(dv_quo);
    end
  end

  always_comb begin
    valid_nxt = 1'b1;
    case (dv_side.src)
      SRC_ZERO: soc_nxt = '0;
      SRC_GAUGE: begin
        if (({1'b0, dv_side.gsoc} > ({1'b0, est} + CLAMP_MARGIN)) && (est < CLAMP_LIMIT)) begin
          soc_nxt = est;
        end else begin
          soc_nxt = dv_side.gsoc;
        end
      end
      SRC_LIN: soc_nxt = est;
      SRC_NONE: begin
        soc_nxt   = '0;
        valid_nxt = 1'b0;
      end
      default: soc_nxt = '0;
    endcase
  end

  logic             out_strobe_r;
  logic [1:0]       out_pack_state_r;
  logic [SOC_W-1:0] out_soc_r;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    out_pack_state_r <= dv_side.pack_state;
    out_soc_r        <= soc_nxt;
    out_valid_r      <= valid_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_pack_state = out_pack_state_r;
  assign out_charge_pct = out_soc_r;
  assign out_soc_valid  = out_valid_r;

  // ---------------- checks
  `BPSC_ASSERT_IMP(a_strobe_matches_accept, out_strobe, $past(in_accept, LATENCY))
  `BPSC_ASSERT_NXT(a_accept_enters_pipe, in_accept, s1_v_r)
  `BPSC_ASSERT_IMP(a_absent_zero_soc, out_strobe && out_pack_state == ST_ABSENT, out_soc_valid && out_charge_pct == '0)
  `BPSC_ASSERT_IMP(a_soc_in_range, out_strobe, out_charge_pct <= SOC_FULL && (out_soc_valid || out_charge_pct == '0))

endmodule

// ===== rtl/bpsc_div.sv =====
module bpsc_div
  import bpsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [MV_W-1:0]  in_den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output side_t            out_side
);

  logic             v_r    [QW];
  logic [NUM_W-1:0] rem_r  [QW];
  logic [MV_W-1:0]  den_r  [QW];
  logic [QW-1:0]    quo_r  [QW];
  side_t            side_r [QW];

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic             v_in;
    logic [NUM_W-1:0] r_in;
    logic [MV_W-1:0]  d_in;
    logic [QW-1:0]    q_in;
    side_t            sd_in;
    logic [NUM_W-1:0] trial;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = in_num;
      assign d_in  = in_den;
      assign q_in  = '0;
      assign sd_in = in_side;
    end else begin : g_next
      assign v_in  = v_r[s-1];
      assign r_in  = rem_r[s-1];
      assign d_in  = den_r[s-1];
      assign q_in  = quo_r[s-1];
      assign sd_in = side_r[s-1];
    end

    assign trial = NUM_W'(d_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      den_r[s]  <= d_in;
      side_r[s] <= sd_in;
      if (r_in >= trial) begin
        rem_r[s] <= r_in - trial;
        quo_r[s] <= q_in | (QW'(1) << SH);
      end else begin
        rem_r[s] <= r_in;
        quo_r[s] <= q_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
